// File: design/gpbmp_pkg.sv
package gpbmp_pkg;

  // Header decode
  localparam logic [31:0] HDR_MASK    = 32'hE003_0003;
  localparam logic [31:0] HDR_INC     = 32'h0000_0000;
  localparam logic [31:0] HDR_NONINC  = 32'h4000_0000;
  localparam logic [10:0] COUNT_MASK  = 11'h7FF;
  localparam logic [15:0] METHOD_MASK = 16'h1FFC;
  localparam logic [15:0] DRAW_METHOD = 16'h17FC;

  localparam int LEN_W = 24;
  localparam int CNT_W = 24;

  // result_kind codes
  localparam logic KIND_WRITE   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Front-to-back queue
  localparam int QUEUE_DEPTH = 4;

  // One accepted word after classification: a method write, a summary, or both.
  typedef struct packed {
    logic             has_write;
    logic             has_sum;
    logic [2:0]       subchannel;
    logic [15:0]      method_address;
    logic [31:0]      method_value;
    logic [CNT_W-1:0] methods_issued;
    logic [CNT_W-1:0] draws_counted;
  } evt_t;

endpackage

// File: design/gpbmp_in_if.sv
interface gpbmp_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;

  modport source (output valid, output data_word, input ready);
  modport sink   (input valid, input data_word, output ready);
endinterface

// File: design/gpbmp_out_if.sv
interface gpbmp_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [2:0]  subchannel;
  logic [15:0] method_address;
  logic [31:0] method_value;
  logic [23:0] methods_issued;
  logic [23:0] draws_counted;
  logic        last;

  modport source (
    output valid, output result_kind, output subchannel, output method_address,
    output method_value, output methods_issued, output draws_counted, output last,
    input ready
  );
  modport sink (
    input valid, input result_kind, input subchannel, input method_address,
    input method_value, input methods_issued, input draws_counted, input last,
    output ready
  );
endinterface

// File: design/gpu_push_buffer_method_parser_core.sv
// Channel   Dir  Handshake        Word contents
// in_chan   in   valid / ready    data_word[31:0]: next command buffer word
// out_chan  out  valid / ready    kind, subchannel, address, value, counts, last
// cfg_*     in   cfg_we only      cfg_wdata[23:0]: buffer length in words
//
// One word is accepted per cycle while the queue has room; the decode and
// counter step happen at the accepting edge. A word that gives a write plus
// the end-of-buffer summary yields two results on out_chan, which leave at
// 1 result per cycle while out_chan.ready is high. An accepted word is written
// to the queue at the accepting edge and then loaded into the output register.
// Synchronous active-low reset clears parser state, queue and output valid.
// in_chan.ready drops only when the 4-entry front/back queue is full.

module gpu_push_buffer_method_parser_core #(
  parameter int POSITION_WIDTH = 24
) (
  input  logic                        clk,
  input  logic                        rst_n,
  gpbmp_in_if.sink                    in_chan,
  gpbmp_out_if.source                 out_chan,
  input  logic                        cfg_we,
  input  logic [gpbmp_pkg::LEN_W-1:0] cfg_wdata
);

  // buffer length register; the user must write it only while idle, the block does not enforce this
  logic [gpbmp_pkg::LEN_W-1:0] buf_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_len_r <= '0;
    end else if (cfg_we) begin
      buf_len_r <= cfg_wdata;
    end
  end

  logic            q_push, q_pop, q_full, q_empty;
  gpbmp_pkg::evt_t q_in, q_head;

  // front: header decode, position tracking, method/draw counters
  gpbmp_front #(
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_chan       (in_chan),
    .buffer_length (buf_len_r),
    .q_full        (q_full),
    .push          (q_push),
    .evt           (q_in)
  );

  // short queue decouples the decoder from output stalls
  gpbmp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  // back: splits a write+summary entry into two results, drives the output register
  gpbmp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .empty    (q_empty),
    .head     (q_head),
    .pop      (q_pop),
    .out_chan (out_chan)
  );

endmodule

// File: design/gpbmp_front.sv
module gpbmp_front #(
  parameter int POSITION_WIDTH = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  gpbmp_in_if.sink                      in_chan,
  input  logic [gpbmp_pkg::LEN_W-1:0]   buffer_length,
  input  logic                          q_full,
  output logic                          push,
  output gpbmp_pkg::evt_t               evt
);

  // wide enough for position + 1 + count and for the length, no wrap
  localparam int CMP_W = (POSITION_WIDTH + 12 > gpbmp_pkg::LEN_W) ?
                         POSITION_WIDTH + 12 : gpbmp_pkg::LEN_W;

  logic [POSITION_WIDTH-1:0]     pos_r,    pos_nxt;
  logic [10:0]                   remain_r, remain_nxt;
  logic [15:0]                   method_r, method_nxt;
  logic [2:0]                    sub_r,    sub_nxt;
  logic                          inc_r,    inc_nxt;
  logic                          pend_r,   pend_nxt;
  logic [gpbmp_pkg::CNT_W-1:0]   mcnt_r,   mcnt_nxt;
  logic [gpbmp_pkg::CNT_W-1:0]   dcnt_r,   dcnt_nxt;

  logic        accept;
  logic [31:0] w;
  logic [31:0] form;
  logic        is_inc, is_non;
  logic [10:0] hdr_cnt;
  logic [15:0] hdr_method;
  logic [CMP_W-1:0] span, len_ext, pos_p1;
  logic        final_word;

  assign in_chan.ready = !q_full;
  assign accept        = in_chan.valid && in_chan.ready;
  assign w             = in_chan.data_word;

  assign form       = w & gpbmp_pkg::HDR_MASK;
  assign is_inc     = (form == gpbmp_pkg::HDR_INC);
  assign is_non     = (form == gpbmp_pkg::HDR_NONINC);
  assign hdr_cnt    = w[28:18] & gpbmp_pkg::COUNT_MASK;
  assign hdr_method = w[15:0] & gpbmp_pkg::METHOD_MASK;

  assign len_ext    = CMP_W'(buffer_length);
  assign pos_p1     = CMP_W'(pos_r) + CMP_W'(1);
  assign span       = pos_p1 + CMP_W'(hdr_cnt);
  assign final_word = (pos_p1 >= len_ext);

  always_comb begin
    pos_nxt    = pos_r + POSITION_WIDTH'(1);
    remain_nxt = remain_r;
    method_nxt = method_r;
    sub_nxt    = sub_r;
    inc_nxt    = inc_r;
    pend_nxt   = pend_r;
    mcnt_nxt   = mcnt_r;
    dcnt_nxt   = dcnt_r;
    evt        = '0;

    if (remain_r != 11'd0) begin
      // data word of an open method
      evt.has_write      = 1'b1;
      evt.subchannel     = sub_r;
      evt.method_address = method_r;
      evt.method_value   = w;
      mcnt_nxt           = mcnt_r + gpbmp_pkg::CNT_W'(1);
      if (pend_r) begin
        if (w != 32'd0) begin
          dcnt_nxt = dcnt_r + gpbmp_pkg::CNT_W'(1);
        end
        pend_nxt = 1'b0;
      end
      if (inc_r) begin
        method_nxt = method_r + 16'd4;
      end
      remain_nxt = remain_r - 11'd1;
    end else if (w != 32'd0 && (is_inc || is_non)) begin
      // header: dropped on zero count or overrun of the buffer end
      if (hdr_cnt != 11'd0 && span <= len_ext) begin
        remain_nxt = hdr_cnt;
        method_nxt = hdr_method;
        sub_nxt    = w[15:13];
        inc_nxt    = is_inc;
        pend_nxt   = is_inc && (hdr_method == gpbmp_pkg::DRAW_METHOD);
      end
    end

    evt.has_sum        = final_word;
    evt.methods_issued = mcnt_nxt;
    evt.draws_counted  = dcnt_nxt;

    if (final_word) begin
      pos_nxt    = '0;
      remain_nxt = '0;
      method_nxt = '0;
      sub_nxt    = '0;
      inc_nxt    = 1'b0;
      pend_nxt   = 1'b0;
      mcnt_nxt   = '0;
      dcnt_nxt   = '0;
    end
  end

  assign push = accept && (evt.has_write || evt.has_sum);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      remain_r <= '0;
      method_r <= '0;
      sub_r    <= '0;
      inc_r    <= 1'b0;
      pend_r   <= 1'b0;
      mcnt_r   <= '0;
      dcnt_r   <= '0;
    end else if (accept) begin
      pos_r    <= pos_nxt;
      remain_r <= remain_nxt;
      method_r <= method_nxt;
      sub_r    <= sub_nxt;
      inc_r    <= inc_nxt;
      pend_r   <= pend_nxt;
      mcnt_r   <= mcnt_nxt;
      dcnt_r   <= dcnt_nxt;
    end
  end

endmodule

// File: design/gpbmp_queue.sv
module gpbmp_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  gpbmp_pkg::evt_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output gpbmp_pkg::evt_t head
);

  localparam int PTR_W = $clog2(gpbmp_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(gpbmp_pkg::QUEUE_DEPTH + 1);

  gpbmp_pkg::evt_t  slots [gpbmp_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r,  count_nxt;

  assign full  = (count_r == CNT_W'(gpbmp_pkg::QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign head  = slots[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// File: design/gpbmp_back.sv
module gpbmp_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            empty,
  input  gpbmp_pkg::evt_t head,
  output logic            pop,
  gpbmp_out_if.source     out_chan
);

  logic                        valid_r,  valid_nxt;
  logic                        phase_r,  phase_nxt;  // write of a two-result entry sent
  logic                        kind_r,   kind_nxt;
  logic [2:0]                  sub_r,    sub_nxt;
  logic [15:0]                 addr_r,   addr_nxt;
  logic [31:0]                 value_r,  value_nxt;
  logic [gpbmp_pkg::CNT_W-1:0] mi_r,     mi_nxt;
  logic [gpbmp_pkg::CNT_W-1:0] dc_r,     dc_nxt;
  logic                        last_r,   last_nxt;

  logic load, take, send_write;

  assign load       = !valid_r || out_chan.ready;
  assign take       = load && !empty;
  assign send_write = head.has_write && !phase_r;

  always_comb begin
    valid_nxt = take || (valid_r && !out_chan.ready);
    phase_nxt = phase_r;
    kind_nxt  = kind_r;
    sub_nxt   = sub_r;
    addr_nxt  = addr_r;
    value_nxt = value_r;
    mi_nxt    = mi_r;
    dc_nxt    = dc_r;
    last_nxt  = last_r;
    pop       = 1'b0;
    if (take) begin
      if (send_write) begin
        kind_nxt  = gpbmp_pkg::KIND_WRITE;
        sub_nxt   = head.subchannel;
        addr_nxt  = head.method_address;
        value_nxt = head.method_value;
        mi_nxt    = '0;
        dc_nxt    = '0;
        last_nxt  = !head.has_sum;
        phase_nxt = head.has_sum;
        pop       = !head.has_sum;
      end else begin
        kind_nxt  = gpbmp_pkg::KIND_SUMMARY;
        sub_nxt   = '0;
        addr_nxt  = '0;
        value_nxt = '0;
        mi_nxt    = head.methods_issued;
        dc_nxt    = head.draws_counted;
        last_nxt  = 1'b1;
        phase_nxt = 1'b0;
        pop       = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      phase_r <= phase_nxt;
    end
    kind_r  <= kind_nxt;
    sub_r   <= sub_nxt;
    addr_r  <= addr_nxt;
    value_r <= value_nxt;
    mi_r    <= mi_nxt;
    dc_r    <= dc_nxt;
    last_r  <= last_nxt;
  end

  assign out_chan.valid          = valid_r;
  assign out_chan.result_kind    = kind_r;
  assign out_chan.subchannel     = sub_r;
  assign out_chan.method_address = addr_r;
  assign out_chan.method_value   = value_r;
  assign out_chan.methods_issued = mi_r;
  assign out_chan.draws_counted  = dc_r;
  assign out_chan.last           = last_r;

endmodule

// File: design/gpbmp_checker.sv
module gpbmp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        result_kind,
  input logic [2:0]  subchannel,
  input logic [15:0] method_address,
  input logic [31:0] method_value,
  input logic [23:0] methods_issued,
  input logic [23:0] draws_counted,
  input logic        last
);

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out valid dropped while stalled");

  a_sum_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && result_kind == gpbmp_pkg::KIND_SUMMARY |-> last)
    else $error("summary not marked last");

  a_write_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && result_kind == gpbmp_pkg::KIND_WRITE |->
      methods_issued == 24'd0 && draws_counted == 24'd0)
    else $error("write carries counts");

  a_sum_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && result_kind == gpbmp_pkg::KIND_SUMMARY |->
      subchannel == 3'd0 && method_address == 16'd0 && method_value == 32'd0)
    else $error("summary carries write fields");

  a_nonlast_then_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !last |=>
      out_valid && result_kind == gpbmp_pkg::KIND_SUMMARY)
    else $error("non-last write not followed by summary");

endmodule

bind gpu_push_buffer_method_parser_core gpbmp_checker u_gpbmp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .result_kind    (out_chan.result_kind),
  .subchannel     (out_chan.subchannel),
  .method_address (out_chan.method_address),
  .method_value   (out_chan.method_value),
  .methods_issued (out_chan.methods_issued),
  .draws_counted  (out_chan.draws_counted),
  .last           (out_chan.last)
);

// File: sim/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int POS_W        = 24;
  localparam int TOTAL_ITEMS  = 450;   // least count of input words, directed rows included
  localparam int DRAIN_CYCLES = 10;    // > accept-to-output latency plus queue depth
  localparam int HOLD_CYCLES  = 80;    // long back-pressure stretch on out_chan
  localparam int CYCLE_LIMIT  = 300000;
  localparam int PRESSURE_BUF = 2;     // random buffer that runs under the long hold
  localparam int QUIET_FIRST  = 150;   // buffers starting at word counts in
  localparam int QUIET_LAST   = 250;   // [QUIET_FIRST, QUIET_LAST) run with no idling
  localparam int IDLE_PCT     = 11;

  typedef struct {
    logic                        kind;
    logic [2:0]                  sub;
    logic [15:0]                 addr;
    logic [31:0]                 value;
    logic [gpbmp_pkg::CNT_W-1:0] methods;
    logic [gpbmp_pkg::CNT_W-1:0] draws;
    logic                        last;
  } method_result_t;

  // One row of the directed plan. Rows with typed set carry their own expected
  // result; the others are checked against the parser mirror below.
  typedef struct {
    bit                          set_len;
    logic [gpbmp_pkg::LEN_W-1:0] len;
    logic [31:0]                 word;
    bit                          typed;
    method_result_t              typed_res;
  } plan_row_t;

  logic                        clk;
  logic                        rst_n;
  logic                        cfg_we;
  logic [gpbmp_pkg::LEN_W-1:0] cfg_wdata;

  gpbmp_in_if  in_chan ();
  gpbmp_out_if out_chan ();

  gpu_push_buffer_method_parser_core #(
    .POSITION_WIDTH(POS_W)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Parser mirror: length register plus the per-buffer decode state.
  // ---------------------------------------------------------------------------
  logic [gpbmp_pkg::LEN_W-1:0] buf_len;
  logic [POS_W-1:0]            word_pos;
  logic [10:0]                 pend_words;
  logic [15:0]                 cur_addr;
  logic [2:0]                  cur_sub;
  bit                          inc_mode;
  bit                          draw_pend;
  logic [gpbmp_pkg::CNT_W-1:0] method_cnt;
  logic [gpbmp_pkg::CNT_W-1:0] draw_cnt;

  method_result_t due_results[$];   // results owed by the DUT, oldest first

  int mismatch_cnt = 0;
  int cycle_cnt    = 0;
  int in_idle_pct  = IDLE_PCT;
  int out_idle_pct = IDLE_PCT;
  bit hold_go      = 1'b0;          // asks the receiver for one long hold-off

  function automatic void clear_parse();
    word_pos   = '0;
    pend_words = '0;
    cur_addr   = '0;
    cur_sub    = '0;
    inc_mode   = 1'b0;
    draw_pend  = 1'b0;
    method_cnt = '0;
    draw_cnt   = '0;
  endfunction

  // Steps the mirror by one accepted word. Results are queued when record is
  // set; done reports that the word closed the buffer.
  task automatic parse_word(input logic [31:0] w, input bit record,
                            output int n_res, output bit done);
    method_result_t outs[$];
    logic [31:0]    form;
    logic [10:0]    cnt;
    bit             end_of_buf;
    if (pend_words != 0) begin
      outs.push_back('{gpbmp_pkg::KIND_WRITE, cur_sub, cur_addr, w, '0, '0, 1'b0});
      method_cnt++;
      // only the first data word of a draw header decides the draw
      if (draw_pend) begin
        if (w != 0) draw_cnt++;
        draw_pend = 1'b0;
      end
      if (inc_mode) cur_addr += 16'd4;
      pend_words--;
    end else if (w != 0) begin
      form = w & gpbmp_pkg::HDR_MASK;
      if (form == gpbmp_pkg::HDR_INC || form == gpbmp_pkg::HDR_NONINC) begin
        cnt = w[28:18] & gpbmp_pkg::COUNT_MASK;
        // zero count or data running past the buffer end: header dropped
        if (cnt != 0 && 32'(word_pos) + 32'd1 + 32'(cnt) <= 32'(buf_len)) begin
          pend_words = cnt;
          cur_addr   = w[15:0] & gpbmp_pkg::METHOD_MASK;
          cur_sub    = w[15:13];
          inc_mode   = (form == gpbmp_pkg::HDR_INC);
          draw_pend  = inc_mode && (cur_addr == gpbmp_pkg::DRAW_METHOD);
        end
      end
    end
    // end test uses the length as it stands now, even if changed mid-buffer
    end_of_buf = (32'(word_pos) + 32'd1 >= 32'(buf_len));
    word_pos++;
    if (end_of_buf) begin
      outs.push_back('{gpbmp_pkg::KIND_SUMMARY, 3'd0, 16'd0, 32'd0, method_cnt, draw_cnt,
                       1'b0});
      clear_parse();
    end
    if (outs.size() > 0) outs[outs.size() - 1].last = 1'b1;
    if (record) foreach (outs[i]) due_results.push_back(outs[i]);
    n_res = outs.size();
    done  = end_of_buf;
  endtask

  function automatic logic [31:0] mk_header(bit inc, logic [10:0] cnt, logic [2:0] sub,
                                            logic [15:0] meth);
    logic [31:0] w;
    w        = inc ? gpbmp_pkg::HDR_INC : gpbmp_pkg::HDR_NONINC;
    w[28:18] = cnt;
    w[15:13] = sub;
    w[12:2]  = meth[12:2];
    return w;
  endfunction

  // Next random word of a buffer. Mostly well-formed: headers that fit,
  // followed by their data; the rest is zero words, zero-count headers,
  // headers that overrun the buffer and raw noise (mostly other forms).
  function automatic logic [31:0] next_buffer_word();
    int          avail;
    int          lo;
    int          r;
    logic [10:0] cnt;
    bit          inc;
    logic [15:0] meth;
    r     = $urandom_range(99);
    avail = int'(buf_len) - int'(word_pos) - 1;
    if (pend_words != 0) return (r < 15) ? 32'h0 : $urandom();
    inc  = $urandom_range(1);
    meth = 16'($urandom());
    if (r < 62) begin
      if (avail < 1) cnt = 11'd1;
      else if (r < 6 && avail <= 64) cnt = 11'(avail);   // data ends exactly at buffer end
      else cnt = 11'($urandom_range(1, (avail < 6) ? avail : 6));
      if ($urandom_range(9) == 0) begin
        inc  = 1'b1;
        meth = gpbmp_pkg::DRAW_METHOD;
      end
      return mk_header(inc, cnt, 3'($urandom()), meth);
    end
    if (r < 72) return 32'h0;
    if (r < 80) return mk_header(inc, 11'd0, 3'($urandom()), meth);
    if (r < 88) begin
      lo = (avail + 1 > 1) ? avail + 1 : 1;
      if (lo <= int'(gpbmp_pkg::COUNT_MASK))
        return mk_header(inc, 11'($urandom_range(lo, int'(gpbmp_pkg::COUNT_MASK))),
                         3'($urandom()), meth);
    end
    return $urandom();
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  task automatic send_word(input logic [31:0] w, input bit record,
                           output int n_res, output bit done);
    while ($urandom_range(99) < in_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.data_word <= w;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    parse_word(w, record, n_res, done);
  endtask

  // Length writes happen only with nothing owed and the pipe drained; a
  // skipped word gives no result, so a few extra cycles cover it.
  task automatic wait_idle();
    in_chan.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_len(input logic [gpbmp_pkg::LEN_W-1:0] len);
    cfg_we    <= 1'b1;
    cfg_wdata <= len;
    @(posedge clk);
    cfg_we    <= 1'b0;
    buf_len    = len;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: random ready, one long hold-off on request, field checks.
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want_v, got_v);
      mismatch_cnt++;
    end
  endfunction

  initial begin
    method_result_t want;
    int             hold_left;
    hold_left       = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_chan.valid && out_chan.ready) begin
        if (due_results.size() == 0) begin
          $error("unexpected result word: kind %0d value %0h",
                 out_chan.result_kind, out_chan.method_value);
          mismatch_cnt++;
        end else begin
          want = due_results.pop_front();
          check_field("result_kind", 32'(want.kind), 32'(out_chan.result_kind));
          check_field("subchannel", 32'(want.sub), 32'(out_chan.subchannel));
          check_field("method_address", 32'(want.addr), 32'(out_chan.method_address));
          check_field("method_value", want.value, out_chan.method_value);
          check_field("methods_issued", 32'(want.methods), 32'(out_chan.methods_issued));
          check_field("draws_counted", 32'(want.draws), 32'(out_chan.draws_counted));
          check_field("last", 32'(want.last), 32'(out_chan.last));
        end
      end
      if (hold_go) begin
        hold_go   = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Clock and watchdog
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $error("timeout after %0d cycles, %0d results still owed", cycle_cnt,
           due_results.size());
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    plan_row_t                   plan[$];
    method_result_t              sum0;
    logic [gpbmp_pkg::LEN_W-1:0] len;
    int                          n_res;
    bit                          done;
    int                          counted;
    int                          buf_idx;
    int                          shrink_at;
    int                          sent;
    int                          r;

    in_chan.valid     <= 1'b0;
    in_chan.data_word <= '0;
    cfg_we            <= 1'b0;
    cfg_wdata         <= '0;
    rst_n             <= 1'b0;
    buf_len            = '0;
    clear_parse();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty summary, the whole result of any word at zero length.
    sum0 = '{gpbmp_pkg::KIND_SUMMARY, 3'd0, 16'd0, 32'd0, '0, '0, 1'b1};

    // Zero length after reset: every word is a one-word buffer.
    plan.push_back('{0, '0, 32'h0000_0000, 1, sum0});
    plan.push_back('{0, '0, 32'hFFFF_FFFF, 1, sum0});
    plan.push_back('{0, '0, mk_header(1, 11'd1, 3'd0, gpbmp_pkg::DRAW_METHOD), 1, sum0});
    // Draw header with nonzero first data, zero word, non-increasing header
    // whose data closes the buffer (write plus summary on one word).
    plan.push_back('{1, 24'd6, mk_header(1, 11'd2, 3'd5, gpbmp_pkg::DRAW_METHOD), 0, sum0});
    plan.push_back('{0, '0, 32'h0000_0001, 0, sum0});
    plan.push_back('{0, '0, 32'hFFFF_FFFF, 0, sum0});
    plan.push_back('{0, '0, 32'h0000_0000, 0, sum0});
    plan.push_back('{0, '0, mk_header(0, 11'd1, 3'd7, 16'h1FFC), 0, sum0});
    plan.push_back('{0, '0, 32'h0000_0000, 0, sum0});
    // Dropped headers: zero count, max count past the end, other form, and a
    // header on the final word.
    plan.push_back('{1, 24'd4, mk_header(1, 11'd0, 3'd3, 16'h0100), 0, sum0});
    plan.push_back('{0, '0, mk_header(0, gpbmp_pkg::COUNT_MASK, 3'd1, 16'h0200), 0, sum0});
    plan.push_back('{0, '0, 32'h2000_0000, 0, sum0});
    plan.push_back('{0, '0, mk_header(1, 11'd1, 3'd2, 16'h0010), 0, sum0});
    // Max length: increasing run, draw header with zero data (no draw),
    // non-increasing draw method (never checked).
    plan.push_back('{1, 24'hFF_FFFF, mk_header(1, 11'd2, 3'd7, 16'h1FFC), 0, sum0});
    plan.push_back('{0, '0, 32'hA5A5_5A5A, 0, sum0});
    plan.push_back('{0, '0, 32'h5A5A_A5A5, 0, sum0});
    plan.push_back('{0, '0, mk_header(1, 11'd1, 3'd0, gpbmp_pkg::DRAW_METHOD), 0, sum0});
    plan.push_back('{0, '0, 32'h0000_0000, 0, sum0});
    plan.push_back('{0, '0, mk_header(0, 11'd2, 3'd4, gpbmp_pkg::DRAW_METHOD), 0, sum0});
    plan.push_back('{0, '0, 32'h0000_0001, 0, sum0});
    plan.push_back('{0, '0, 32'h0000_0002, 0, sum0});
    plan.push_back('{0, '0, mk_header(1, 11'd3, 3'd6, 16'h0040), 0, sum0});
    plan.push_back('{0, '0, 32'h1234_5678, 0, sum0});
    // Shrink the length mid-buffer: next data word closes it, one data word
    // is abandoned.
    plan.push_back('{1, 24'd2, 32'h8765_4321, 0, sum0});

    foreach (plan[i]) begin
      if (plan[i].set_len) begin
        wait_idle();
        write_len(plan[i].len);
      end
      send_word(plan[i].word, !plan[i].typed, n_res, done);
      if (plan[i].typed) due_results.push_back(plan[i].typed_res);
    end

    // Random buffers. Most are short; some long, some at zero length, and some
    // huge ones cut short by a length write mid-buffer.
    counted = plan.size();
    buf_idx = 0;
    while (counted < TOTAL_ITEMS) begin
      in_idle_pct  = (counted >= QUIET_FIRST && counted < QUIET_LAST) ? 0 : IDLE_PCT;
      out_idle_pct = in_idle_pct;
      shrink_at    = 0;
      r            = $urandom_range(99);
      if (buf_idx == PRESSURE_BUF) len = 24'd60;
      else if (r < 10) len = '0;
      else if (r < 75) len = gpbmp_pkg::LEN_W'($urandom_range(1, 24));
      else if (r < 90) len = gpbmp_pkg::LEN_W'($urandom_range(25, 120));
      else begin
        len       = (r < 95) ? 24'hFF_FFFF : gpbmp_pkg::LEN_W'($urandom());
        shrink_at = $urandom_range(3, 30);
      end
      wait_idle();
      write_len(len);
      if (buf_idx == PRESSURE_BUF) hold_go = 1'b1;
      done = 1'b0;
      sent = 0;
      while (!done) begin
        if (shrink_at != 0 && sent == shrink_at) begin
          wait_idle();
          write_len(gpbmp_pkg::LEN_W'($urandom_range(0, int'(word_pos))));
        end
        send_word(next_buffer_word(), 1, n_res, done);
        sent++;
        counted++;
      end
      buf_idx++;
    end

    in_chan.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
